/* rtl/core/chw_pkg.sv */
// shared constants, types and control structs of the conflict-history weight block
// no dependencies; used by every file under rtl/core
package chw_pkg;

    localparam int NUM_CONSTRAINTS = 1024;
    localparam int FRAC_BITS       = 24;

    localparam int IDX_W   = 10;
    localparam int ADDR_W  = (NUM_CONSTRAINTS > 1) ? $clog2(NUM_CONSTRAINTS) : 1;
    localparam int W_W     = FRAC_BITS + 1;
    localparam int CFG_W   = 25;
    localparam int DEC_W   = 16;
    localparam int CNT_W   = 32;
    localparam int CON_W   = 26;
    localparam int DVR_W   = CNT_W + 1;
    localparam int REM_W   = CNT_W + 2;
    localparam int DCNT_W  = $clog2(FRAC_BITS + 1);
    localparam int CIDX_W  = 2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [W_W-1:0]    t_frac;

    localparam t_frac FX_ONE = t_frac'(1) << FRAC_BITS;

    // configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_ALPHA_INITIAL = 2'd0,
        CFG_ALPHA_MINIMUM = 2'd1,
        CFG_ALPHA_DECAY   = 2'd2,
        CFG_SCORE_OFFSET  = 2'd3
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] ALPHA_INITIAL_RST = 25'd6710886;
    localparam logic [CFG_W-1:0] ALPHA_MINIMUM_RST = 25'd1006633;
    localparam logic [DEC_W-1:0] ALPHA_DECAY_RST   = 16'd17;
    localparam logic [CFG_W-1:0] SCORE_OFFSET_RST  = 25'd1678;

    localparam logic OP_CONFLICT = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic div_init;
        logic div_step;
        logic mul_r;
        logic mul_w;
        logic update;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic div_last;
        logic is_query;
        logic in_range;
    } t_stat;

    function automatic t_frac clamp_one(input logic [CFG_W-1:0] v);
        t_frac res;
        res = (W_W'(v) > FX_ONE) ? FX_ONE : W_W'(v);
        return res;
    endfunction

endpackage

/* rtl/core/chw_in_if.sv */
// request channel: op and constraint index with valid/ready
// depends on chw_pkg
interface chw_in_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [chw_pkg::IDX_W-1:0] cstr_idx;

    modport source (output valid, output op, output cstr_idx, input ready);
    modport sink   (input valid, input op, input cstr_idx, output ready);
endinterface

/* rtl/core/chw_out_if.sv */
// result channel: contribution and conflict count with valid/ready
// depends on chw_pkg
interface chw_out_if;
    logic                     valid;
    logic                     ready;
    logic [chw_pkg::CON_W-1:0] contribution;
    logic [chw_pkg::CNT_W-1:0] conflict_count;

    modport source (output valid, output contribution, output conflict_count, input ready);
    modport sink   (input valid, input contribution, input conflict_count, output ready);
endinterface

/* rtl/core/chw_ctrl.sv */
// sequencer of the weight update: clear pass, load, divide, multiply, write back
// depends on chw_pkg
module chw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  chw_pkg::t_stat i_stat,
    output chw_pkg::t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_CLEAR  = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_LOAD   = 8'b0000_0100,
        S_DIV    = 8'b0000_1000,
        S_MUL1   = 8'b0001_0000,
        S_MUL2   = 8'b0010_0000,
        S_UPDATE = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOAD;
                end
            end
            S_LOAD: begin
                if (i_stat.is_query || !i_stat.in_range) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.mul_r = 1'b1;
                n_state     = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.mul_w = 1'b1;
                n_state     = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_FINISH;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/core/chw_dpath.sv */
// datapath: score and last-conflict memories, restoring divider, shared multiplier,
// configuration registers and output register; depends on chw_pkg
module chw_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [chw_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [chw_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_op,
    input  logic [chw_pkg::IDX_W-1:0]     i_cstr_idx,
    input  chw_pkg::t_cmd                 i_cmd,
    output chw_pkg::t_stat                o_stat,
    output logic [chw_pkg::CON_W-1:0]     o_contribution,
    output logic [chw_pkg::CNT_W-1:0]     o_conflict_count
);

    // storage
    chw_pkg::t_frac            mem_score [chw_pkg::NUM_CONSTRAINTS];
    logic [chw_pkg::CNT_W-1:0] mem_last  [chw_pkg::NUM_CONSTRAINTS];

    // configuration and global state
    logic [chw_pkg::CFG_W-1:0] r_alpha_min, r_offset;
    logic [chw_pkg::DEC_W-1:0] r_alpha_dec;
    chw_pkg::t_frac            r_alpha;
    logic [chw_pkg::CNT_W-1:0] r_counter;
    chw_pkg::t_addr            r_clr_addr;

    // per-item registers
    chw_pkg::t_addr            r_addr;
    logic                      r_query, r_in_range;
    chw_pkg::t_frac            r_w;
    logic [chw_pkg::CNT_W-1:0] r_last;
    logic [chw_pkg::DVR_W-1:0] r_divisor;
    logic [chw_pkg::REM_W-1:0] r_rem;
    chw_pkg::t_frac            r_quo;
    logic [chw_pkg::DCNT_W-1:0] r_dcnt;
    chw_pkg::t_frac            r_term_r, r_term_w;
    logic [chw_pkg::CON_W-1:0] r_contrib;

    logic                      in_range;
    logic [chw_pkg::CNT_W-1:0] gap;
    logic [chw_pkg::REM_W-1:0] rem_sh;
    logic                      rem_ge;
    chw_pkg::t_frac            mul_a, mul_b;
    logic [2*chw_pkg::W_W-1:0] prod;
    logic [chw_pkg::W_W:0]     w_sum;
    chw_pkg::t_frac            w_new;
    logic [chw_pkg::CNT_W-1:0] cnt_next;
    chw_pkg::t_frac            alpha_sub, alpha_floor, alpha_next;
    chw_pkg::t_frac            w_out;
    logic [chw_pkg::CON_W:0]   con_sum;

    assign in_range = 32'(i_cstr_idx) < 32'(chw_pkg::NUM_CONSTRAINTS);

    assign o_stat.clr_done = (r_clr_addr == chw_pkg::t_addr'(chw_pkg::NUM_CONSTRAINTS - 1));
    assign o_stat.div_last = (r_dcnt == '0);
    assign o_stat.is_query = r_query;
    assign o_stat.in_range = r_in_range;

    // gap since the last conflict; gap plus one is the divisor of one
    assign gap = r_counter - r_last;

    // restoring division step; the single set dividend bit enters on the first step
    assign rem_sh = {r_rem[chw_pkg::REM_W-2:0],
                     (r_dcnt == chw_pkg::DCNT_W'(chw_pkg::FRAC_BITS))};
    assign rem_ge = rem_sh >= chw_pkg::REM_W'(r_divisor);

    // one shared multiplier: alpha * r, then (1 - alpha) * w
    assign mul_a = i_cmd.mul_r ? r_alpha : (chw_pkg::FX_ONE - r_alpha);
    assign mul_b = i_cmd.mul_r ? r_quo : r_w;
    assign prod  = mul_a * mul_b;

    assign w_sum = (chw_pkg::W_W + 1)'(r_term_r) + (chw_pkg::W_W + 1)'(r_term_w);
    assign w_new = (w_sum > (chw_pkg::W_W + 1)'(chw_pkg::FX_ONE))
                   ? chw_pkg::FX_ONE : w_sum[chw_pkg::W_W-1:0];

    assign cnt_next = (r_counter != '1) ? r_counter + 1'b1 : r_counter;

    assign alpha_sub   = (r_alpha >= chw_pkg::W_W'(r_alpha_dec))
                         ? r_alpha - chw_pkg::W_W'(r_alpha_dec) : '0;
    assign alpha_floor = chw_pkg::clamp_one(r_alpha_min);
    assign alpha_next  = (alpha_sub < alpha_floor) ? alpha_floor : alpha_sub;

    // result: weight (zero for an out-of-range index) plus offset, saturating
    assign w_out   = r_in_range ? r_w : '0;
    assign con_sum = (chw_pkg::CON_W + 1)'(w_out) + (chw_pkg::CON_W + 1)'(r_offset);

    // memories, no reset: cleared by the sweep after reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem_score[r_clr_addr] <= '0;
            mem_last[r_clr_addr]  <= '0;
        end else if (i_cmd.update) begin
            mem_score[r_addr] <= w_new;
            mem_last[r_addr]  <= cnt_next;
        end
        if (i_cmd.capture) begin
            r_w    <= mem_score[chw_pkg::t_addr'(i_cstr_idx)];
            r_last <= mem_last[chw_pkg::t_addr'(i_cstr_idx)];
        end else if (i_cmd.update) begin
            r_w <= w_new;
        end
    end

    // control state: configuration, alpha, counter, sweep address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_min  <= chw_pkg::ALPHA_MINIMUM_RST;
            r_alpha_dec  <= chw_pkg::ALPHA_DECAY_RST;
            r_offset     <= chw_pkg::SCORE_OFFSET_RST;
            r_alpha      <= chw_pkg::clamp_one(chw_pkg::ALPHA_INITIAL_RST);
            r_counter    <= '0;
            r_clr_addr   <= '0;
        end else begin
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.update) begin
                r_counter <= cnt_next;
                r_alpha   <= alpha_next;
            end
            if (i_cfg_we) begin
                unique case (chw_pkg::t_cfg_idx'(i_cfg_index))
                    // alpha restarts from the written value
                    chw_pkg::CFG_ALPHA_INITIAL: r_alpha <= chw_pkg::clamp_one(i_cfg_data);
                    chw_pkg::CFG_ALPHA_MINIMUM: r_alpha_min <= i_cfg_data;
                    chw_pkg::CFG_ALPHA_DECAY:   r_alpha_dec <= i_cfg_data[chw_pkg::DEC_W-1:0];
                    chw_pkg::CFG_SCORE_OFFSET:  r_offset    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // per-item payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_addr     <= chw_pkg::t_addr'(i_cstr_idx);
            r_query    <= (i_op == chw_pkg::OP_QUERY);
            r_in_range <= in_range;
        end
        if (i_cmd.div_init) begin
            r_divisor <= chw_pkg::DVR_W'(gap) + 1'b1;
            r_rem     <= '0;
            r_quo     <= '0;
            r_dcnt    <= chw_pkg::DCNT_W'(chw_pkg::FRAC_BITS);
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? rem_sh - chw_pkg::REM_W'(r_divisor) : rem_sh;
            r_quo  <= {r_quo[chw_pkg::W_W-2:0], rem_ge};
            r_dcnt <= r_dcnt - 1'b1;
        end
        if (i_cmd.mul_r) r_term_r <= prod[chw_pkg::FRAC_BITS +: chw_pkg::W_W];
        if (i_cmd.mul_w) r_term_w <= prod[chw_pkg::FRAC_BITS +: chw_pkg::W_W];
        if (i_cmd.load_out) begin
            r_contrib <= con_sum[chw_pkg::CON_W] ? '1 : con_sum[chw_pkg::CON_W-1:0];
        end
    end

    assign o_contribution   = r_contrib;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) o_conflict_count <= r_counter;
    end

endmodule

/* rtl/core/conflict_history_weight_update.sv */
// top level of the conflict-history weight block: sequencer plus datapath
// depends on chw_pkg, chw_in_if, chw_out_if, chw_ctrl, chw_dpath
//
// usage
//  - i_in carries items with op (conflict or query) and cstr_idx;
//    o_out returns exactly one item per request: contribution (weight plus
//    score offset, saturating) and the conflict count after the step
//  - configuration is a plain write port: i_cfg_we, i_cfg_index, i_cfg_data;
//    writing alpha_initial also restarts the live alpha
//  - after reset the score and last-conflict memories are swept to zero,
//    one entry a cycle, while i_in.ready stays low;
//    configuration writes are taken during the sweep
//  - a query passes the load and finish states straight to the output
//    register; so does a conflict on an out-of-range index
//  - an in-range conflict runs a 25-step restoring divider for 1/(gap+1), two
//    passes through one 25x25 multiplier and a write-back before its result
//    is registered; a new item is accepted only once the last one is done
//  - the result sits in an output register, so the next item is accepted
//    while a finished one waits; a stalled receiver holds the block only
//    once the next result is ready to be written
module conflict_history_weight_update (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [chw_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [chw_pkg::CFG_W-1:0]  i_cfg_data,
    chw_in_if.sink                     i_in,
    chw_out_if.source                  o_out
);

    chw_pkg::t_cmd  cmd;
    chw_pkg::t_stat stat;

    // sequencer owns the handshakes and the output valid flag
    chw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // memories, arithmetic and the output payload register
    chw_dpath u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_op               (i_in.op),
        .i_cstr_idx         (i_in.cstr_idx),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .o_contribution     (o_out.contribution),
        .o_conflict_count   (o_out.conflict_count)
    );

endmodule
